// ===== rtl/vrm_pkg.sv =====
// Shared types and constants for the vector-align rotation matrix unit.
// Used by the unit itself and by its interface checker; no dependencies.
package vrm_pkg;

    // One vector pair: source and target, signed integers of any scale.
    typedef struct packed {
        logic signed [15:0] from_x;
        logic signed [15:0] from_y;
        logic signed [15:0] from_z;
        logic signed [15:0] to_x;
        logic signed [15:0] to_y;
        logic signed [15:0] to_z;
    } vrm_in_t;

    // Rotation matrix in Q2.14, row-major, plus the degenerate flag.
    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic               degenerate;
    } vrm_out_t;

    // 1.0 in Q2.14, also the saturation bound of every entry.
    localparam logic signed [15:0] OUT_ONE = 16'sd16384;

endpackage

// ===== rtl/vector_align_rotation_matrix_unit.sv =====
// Rotation matrix that turns one 3-D vector onto another (Rodrigues form).
// Depends on vrm_pkg for the transaction types.

// The unit takes vector pairs and returns for each one the 3x3 rotation matrix
// R = I + V + V^2/(1+c) in Q2.14 that turns the source direction onto the
// target direction. It is built from bit-serial stages: a 31-stage square root
// for the vector norms, a 32-stage divider for normalization and a 34-stage
// divider for the 1/(1+c) term, each stage resolving one root or quotient bit but
// for the overflow check that opens each divider, plus stages of multiply, sum
// and round. Throughput is one transaction per cycle while the output buffer is
// not full. A zero-length input or nearly opposite vectors (1+c at most 2^-14)
// give the identity with degenerate set; parallel vectors give the identity with
// degenerate clear. A two-entry output buffer lets the unit keep taking pairs
// after the output side stalls, until both entries fill.
module vector_align_rotation_matrix_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vec_valid,
    output logic               vec_ready,
    input  vrm_pkg::vrm_in_t   vec,
    output logic               rot_valid,
    input  logic               rot_ready,
    output vrm_pkg::vrm_out_t  rot
);

    localparam int SQ_BITS = 31;   // root bits of norm * 2^15
    localparam int UQ_BITS = 31;   // quotient bits of a unit component
    localparam int WQ_BITS = 33;   // quotient bits of V^2 / (1+c)

    localparam int ST_DV0 = SQ_BITS + 1;
    localparam int ST_UN  = ST_DV0 + UQ_BITS + 2;
    localparam int ST_PR  = ST_UN + 1;
    localparam int ST_CV  = ST_PR + 1;
    localparam int ST_VP  = ST_CV + 1;
    localparam int ST_W   = ST_VP + 1;
    localparam int ST_DW0 = ST_W + 1;
    localparam int ST_E   = ST_DW0 + WQ_BITS + 2;
    localparam int ST_R   = ST_E + 1;
    localparam int NST    = ST_R + 1;

    // entry (row-major) -> index of its V^2/(1+c) term (symmetric)
    localparam int TIDX [9] = '{0, 3, 4, 3, 1, 5, 4, 5, 2};

    function automatic logic [31:0] sqr16(input logic signed [15:0] x);
        logic signed [31:0] p;
        p = x * x;
        return p;
    endfunction

    // divide by 2^30, rounded half away from zero
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] x);
        logic [63:0]        mag;
        logic [33:0]        q;
        logic signed [34:0] sq;
        mag = x[63] ? 64'(-x) : x;
        q   = 34'((mag + 64'h2000_0000) >> 30);
        sq  = {1'b0, q};
        return 34'(x[63] ? -sq : sq);
    endfunction

    logic pipe_en;
    logic [NST-1:0] vld_reg;

    // ---------------- norm squared and square root ----------------
    logic [61:0]      sq_rem_reg  [0:SQ_BITS][0:1];
    logic [30:0]      sq_root_reg [0:SQ_BITS][0:1];
    vrm_pkg::vrm_in_t sq_vec_reg  [0:SQ_BITS];
    logic [1:0]       sq_zero_reg [0:SQ_BITS];

    logic [31:0] norm_a, norm_b;

    always_comb
    begin
        norm_a = sqr16(vec.from_x) + sqr16(vec.from_y) + sqr16(vec.from_z);
        norm_b = sqr16(vec.to_x) + sqr16(vec.to_y) + sqr16(vec.to_z);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sq_rem_reg[0][0]  <= {norm_a, 30'b0};
            sq_rem_reg[0][1]  <= {norm_b, 30'b0};
            sq_root_reg[0][0] <= '0;
            sq_root_reg[0][1] <= '0;
            sq_vec_reg[0]     <= vec;
            sq_zero_reg[0]    <= {norm_b == 32'd0, norm_a == 32'd0};
        end
    end

    for (genvar k = 1; k <= SQ_BITS; k++)
    begin : g_sqrt
        localparam int I = SQ_BITS - k;
        logic [62:0] trial [0:1];
        logic        ge    [0:1];

        always_comb
        begin
            for (int n = 0; n < 2; n++)
            begin
                trial[n] = ({32'b0, sq_root_reg[k-1][n]} << (I + 1)) + (63'd1 << (2 * I));
                ge[n]    = {1'b0, sq_rem_reg[k-1][n]} >= trial[n];
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                for (int n = 0; n < 2; n++)
                begin
                    sq_rem_reg[k][n]  <= ge[n] ? sq_rem_reg[k-1][n] - trial[n][61:0]
                                               : sq_rem_reg[k-1][n];
                    sq_root_reg[k][n] <= sq_root_reg[k-1][n] | (ge[n] ? 31'(1) << I : 31'd0);
                end
                sq_vec_reg[k]  <= sq_vec_reg[k-1];
                sq_zero_reg[k] <= sq_zero_reg[k-1];
            end
        end
    end

    // ---------------- normalization divider ----------------
    logic [60:0] dv_rem_reg  [0:UQ_BITS+1][0:5];
    logic [30:0] dv_q_reg    [0:UQ_BITS+1][0:5];
    logic [5:0]  dv_ovf_reg  [0:UQ_BITS+1];
    logic [5:0]  dv_neg_reg  [0:UQ_BITS+1];
    logic [30:0] dv_s_reg    [0:UQ_BITS+1][0:1];
    logic [1:0]  dv_zero_reg [0:UQ_BITS+1];

    logic signed [15:0] comp [0:5];
    logic [15:0]        comp_mag [0:5];

    always_comb
    begin
        comp[0] = sq_vec_reg[SQ_BITS].from_x;
        comp[1] = sq_vec_reg[SQ_BITS].from_y;
        comp[2] = sq_vec_reg[SQ_BITS].from_z;
        comp[3] = sq_vec_reg[SQ_BITS].to_x;
        comp[4] = sq_vec_reg[SQ_BITS].to_y;
        comp[5] = sq_vec_reg[SQ_BITS].to_z;
        for (int l = 0; l < 6; l++)
            comp_mag[l] = comp[l][15] ? 16'(-comp[l]) : comp[l];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int l = 0; l < 6; l++)
            begin
                // |comp| * 2^45 + s/2, ready for a rounded quotient
                dv_rem_reg[0][l] <= {comp_mag[l], 45'b0}
                                  + {31'b0, sq_root_reg[SQ_BITS][l / 3][30:1]};
                dv_q_reg[0][l]   <= '0;
                dv_neg_reg[0][l] <= comp[l][15];
            end
            dv_ovf_reg[0]  <= '0;
            dv_s_reg[0][0] <= sq_root_reg[SQ_BITS][0];
            dv_s_reg[0][1] <= sq_root_reg[SQ_BITS][1];
            dv_zero_reg[0] <= sq_zero_reg[SQ_BITS];
        end
    end

    for (genvar k = 1; k <= UQ_BITS + 1; k++)
    begin : g_udiv
        logic [61:0] dsr [0:5];
        logic        ge  [0:5];

        always_comb
        begin
            for (int l = 0; l < 6; l++)
            begin
                if (k == 1)
                    dsr[l] = {dv_s_reg[k-1][l / 3], 31'b0};
                else
                    dsr[l] = {31'b0, dv_s_reg[k-1][l / 3]} << (UQ_BITS + 1 - k);
                ge[l] = {1'b0, dv_rem_reg[k-1][l]} >= dsr[l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                for (int l = 0; l < 6; l++)
                begin
                    if (k == 1)
                    begin
                        // quotient would not fit: result clamps to 1.0
                        dv_rem_reg[k][l] <= dv_rem_reg[k-1][l];
                        dv_q_reg[k][l]   <= dv_q_reg[k-1][l];
                        dv_ovf_reg[k][l] <= ge[l];
                    end
                    else
                    begin
                        dv_rem_reg[k][l] <= ge[l] ? dv_rem_reg[k-1][l] - dsr[l][60:0]
                                                  : dv_rem_reg[k-1][l];
                        dv_q_reg[k][l]   <= dv_q_reg[k-1][l]
                                          | (ge[l] ? 31'(1) << (UQ_BITS + 1 - k) : 31'd0);
                        dv_ovf_reg[k][l] <= dv_ovf_reg[k-1][l];
                    end
                    dv_neg_reg[k][l] <= dv_neg_reg[k-1][l];
                end
                dv_s_reg[k]    <= dv_s_reg[k-1];
                dv_zero_reg[k] <= dv_zero_reg[k-1];
            end
        end
    end

    // ---------------- unit vectors, products, c and v ----------------
    logic signed [31:0] un_reg [0:5];
    logic               un_dg_reg;
    logic signed [61:0] pr_reg [0:8];
    logic               pr_dg_reg;
    logic signed [31:0] cv_v_reg [0:2];
    logic [32:0]        cv_d_reg;
    logic               cv_dg_reg;

    logic [30:0] unit_mag [0:5];

    always_comb
    begin
        for (int l = 0; l < 6; l++)
            unit_mag[l] = (dv_ovf_reg[UQ_BITS+1][l] || dv_q_reg[UQ_BITS+1][l] > 31'h4000_0000)
                        ? 31'h4000_0000 : dv_q_reg[UQ_BITS+1][l];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int l = 0; l < 6; l++)
                un_reg[l] <= dv_neg_reg[UQ_BITS+1][l] ? -$signed({1'b0, unit_mag[l]})
                                                      : $signed({1'b0, unit_mag[l]});
            un_dg_reg <= |dv_zero_reg[UQ_BITS+1];
        end
    end

    logic signed [63:0] prod [0:8];

    always_comb
    begin
        prod[0] = un_reg[0] * un_reg[3];
        prod[1] = un_reg[1] * un_reg[4];
        prod[2] = un_reg[2] * un_reg[5];
        prod[3] = un_reg[1] * un_reg[5];
        prod[4] = un_reg[2] * un_reg[4];
        prod[5] = un_reg[2] * un_reg[3];
        prod[6] = un_reg[0] * un_reg[5];
        prod[7] = un_reg[0] * un_reg[4];
        prod[8] = un_reg[1] * un_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int p = 0; p < 9; p++)
                pr_reg[p] <= prod[p][61:0];
            pr_dg_reg <= un_dg_reg;
        end
    end

    logic signed [63:0] dot_sum;
    logic signed [63:0] crs_sum [0:2];
    logic signed [33:0] cos_q30;
    logic signed [33:0] den;
    logic signed [33:0] crs_q30 [0:2];

    always_comb
    begin
        dot_sum    = pr_reg[0] + pr_reg[1] + pr_reg[2];
        crs_sum[0] = pr_reg[3] - pr_reg[4];
        crs_sum[1] = pr_reg[5] - pr_reg[6];
        crs_sum[2] = pr_reg[7] - pr_reg[8];
        cos_q30    = rnd30(dot_sum);
        den        = cos_q30 + 34'sh0_4000_0000;
        for (int n = 0; n < 3; n++)
            crs_q30[n] = rnd30(crs_sum[n]);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int n = 0; n < 3; n++)
                cv_v_reg[n] <= crs_q30[n][31:0];
            cv_d_reg  <= den[32:0];
            // nearly opposite: 1+c at most 2^-14
            cv_dg_reg <= pr_dg_reg || den <= 34'sd65536;
        end
    end

    // ---------------- V^2 ----------------
    logic signed [63:0] vp_reg [0:5];
    logic signed [31:0] vp_v_reg [0:2];
    logic [32:0]        vp_d_reg;
    logic               vp_dg_reg;
    logic signed [64:0] w_reg [0:5];
    logic signed [31:0] w_v_reg [0:2];
    logic [32:0]        w_d_reg;
    logic               w_dg_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            vp_reg[0] <= cv_v_reg[0] * cv_v_reg[0];
            vp_reg[1] <= cv_v_reg[1] * cv_v_reg[1];
            vp_reg[2] <= cv_v_reg[2] * cv_v_reg[2];
            vp_reg[3] <= cv_v_reg[0] * cv_v_reg[1];
            vp_reg[4] <= cv_v_reg[0] * cv_v_reg[2];
            vp_reg[5] <= cv_v_reg[1] * cv_v_reg[2];
            vp_v_reg  <= cv_v_reg;
            vp_d_reg  <= cv_d_reg;
            vp_dg_reg <= cv_dg_reg;
        end
    end

    // V*V = v v^T - |v|^2 I
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            w_reg[0] <= -(65'(vp_reg[1]) + 65'(vp_reg[2]));
            w_reg[1] <= -(65'(vp_reg[0]) + 65'(vp_reg[2]));
            w_reg[2] <= -(65'(vp_reg[0]) + 65'(vp_reg[1]));
            w_reg[3] <= 65'(vp_reg[3]);
            w_reg[4] <= 65'(vp_reg[4]);
            w_reg[5] <= 65'(vp_reg[5]);
            w_v_reg  <= vp_v_reg;
            w_d_reg  <= vp_d_reg;
            w_dg_reg <= vp_dg_reg;
        end
    end

    // ---------------- V^2 / (1+c) divider ----------------
    logic [64:0]        dw_rem_reg [0:WQ_BITS+1][0:5];
    logic [32:0]        dw_q_reg   [0:WQ_BITS+1][0:5];
    logic [5:0]         dw_ovf_reg [0:WQ_BITS+1];
    logic [5:0]         dw_neg_reg [0:WQ_BITS+1];
    logic [32:0]        dw_d_reg   [0:WQ_BITS+1];
    logic signed [31:0] dw_v_reg   [0:WQ_BITS+1][0:2];
    logic               dw_dg_reg  [0:WQ_BITS+1];

    logic [63:0] w_mag [0:5];

    always_comb
    begin
        for (int l = 0; l < 6; l++)
            w_mag[l] = w_reg[l][64] ? 64'(-w_reg[l]) : w_reg[l][63:0];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int l = 0; l < 6; l++)
            begin
                dw_rem_reg[0][l] <= {1'b0, w_mag[l]} + {33'b0, w_d_reg[32:1]};
                dw_q_reg[0][l]   <= '0;
                dw_neg_reg[0][l] <= w_reg[l][64];
            end
            dw_ovf_reg[0] <= '0;
            dw_d_reg[0]   <= w_d_reg;
            dw_v_reg[0]   <= w_v_reg;
            dw_dg_reg[0]  <= w_dg_reg;
        end
    end

    for (genvar k = 1; k <= WQ_BITS + 1; k++)
    begin : g_wdiv
        logic [65:0] dsr;
        logic        ge [0:5];

        always_comb
        begin
            if (k == 1)
                dsr = {dw_d_reg[k-1], 33'b0};
            else
                dsr = {33'b0, dw_d_reg[k-1]} << (WQ_BITS + 1 - k);
            for (int l = 0; l < 6; l++)
                ge[l] = {1'b0, dw_rem_reg[k-1][l]} >= dsr;
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                for (int l = 0; l < 6; l++)
                begin
                    if (k == 1)
                    begin
                        // oversized quotient saturates the entry anyway
                        dw_rem_reg[k][l] <= dw_rem_reg[k-1][l];
                        dw_q_reg[k][l]   <= dw_q_reg[k-1][l];
                        dw_ovf_reg[k][l] <= ge[l];
                    end
                    else
                    begin
                        dw_rem_reg[k][l] <= ge[l] ? dw_rem_reg[k-1][l] - dsr[64:0]
                                                  : dw_rem_reg[k-1][l];
                        dw_q_reg[k][l]   <= dw_q_reg[k-1][l]
                                          | (ge[l] ? 33'(1) << (WQ_BITS + 1 - k) : 33'd0);
                        dw_ovf_reg[k][l] <= dw_ovf_reg[k-1][l];
                    end
                    dw_neg_reg[k][l] <= dw_neg_reg[k-1][l];
                end
                dw_d_reg[k]  <= dw_d_reg[k-1];
                dw_v_reg[k]  <= dw_v_reg[k-1];
                dw_dg_reg[k] <= dw_dg_reg[k-1];
            end
        end
    end

    // ---------------- entries, rounding, saturation ----------------
    logic signed [35:0] e_reg [0:8];
    logic               e_dg_reg;

    logic signed [35:0] vx  [0:2];
    logic signed [35:0] vm  [0:8];
    logic signed [35:0] tq  [0:5];
    logic [32:0]        tqm [0:5];

    always_comb
    begin
        for (int n = 0; n < 3; n++)
            vx[n] = 36'(dw_v_reg[WQ_BITS+1][n]);
        vm[0] = '0;     vm[1] = -vx[2]; vm[2] = vx[1];
        vm[3] = vx[2];  vm[4] = '0;     vm[5] = -vx[0];
        vm[6] = -vx[1]; vm[7] = vx[0];  vm[8] = '0;
        for (int l = 0; l < 6; l++)
        begin
            tqm[l] = dw_ovf_reg[WQ_BITS+1][l] ? '1 : dw_q_reg[WQ_BITS+1][l];
            tq[l]  = dw_neg_reg[WQ_BITS+1][l] ? -$signed({3'b0, tqm[l]})
                                              : $signed({3'b0, tqm[l]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int p = 0; p < 9; p++)
                e_reg[p] <= ((p % 4 == 0) ? 36'sh0_4000_0000 : 36'sd0) + vm[p] + tq[TIDX[p]];
            e_dg_reg <= dw_dg_reg[WQ_BITS+1];
        end
    end

    logic [35:0]        e_mag [0:8];
    logic [20:0]        e_q16 [0:8];
    logic [14:0]        e_sat [0:8];
    logic signed [15:0] ent   [0:8];
    vrm_pkg::vrm_out_t  res;
    vrm_pkg::vrm_out_t  r_reg;

    always_comb
    begin
        for (int p = 0; p < 9; p++)
        begin
            e_mag[p] = e_reg[p][35] ? 36'(-e_reg[p]) : e_reg[p];
            e_q16[p] = 21'((e_mag[p] + 36'd32768) >> 16);
            e_sat[p] = (e_q16[p] > 21'd16384) ? 15'd16384 : e_q16[p][14:0];
            if (e_dg_reg)
                ent[p] = (p % 4 == 0) ? vrm_pkg::OUT_ONE : 16'sd0;
            else
                ent[p] = e_reg[p][35] ? -$signed({1'b0, e_sat[p]}) : $signed({1'b0, e_sat[p]});
        end
        res.r00 = ent[0]; res.r01 = ent[1]; res.r02 = ent[2];
        res.r10 = ent[3]; res.r11 = ent[4]; res.r12 = ent[5];
        res.r20 = ent[6]; res.r21 = ent[7]; res.r22 = ent[8];
        res.degenerate = e_dg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            r_reg <= res;
    end

    // ---------------- valid chain and output buffer ----------------
    logic              rot_valid_reg, rot_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    vrm_pkg::vrm_out_t rot_reg, skid_reg;
    logic              take, rot_load_pipe, rot_load_skid, skid_load;

    assign pipe_en   = !skid_valid_reg;
    assign vec_ready = pipe_en;
    assign take      = rot_valid_reg && rot_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_en)
            vld_reg <= {vld_reg[NST-2:0], vec_valid && vec_ready};
    end

    always_comb
    begin
        rot_valid_next  = rot_valid_reg;
        skid_valid_next = skid_valid_reg;
        rot_load_pipe   = 1'b0;
        rot_load_skid   = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                rot_load_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (vld_reg[NST-1])
        begin
            if (!rot_valid_reg || take)
            begin
                rot_load_pipe  = 1'b1;
                rot_valid_next = 1'b1;
            end
            else
            begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            rot_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            rot_valid_reg  <= rot_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rot_load_pipe)
            rot_reg <= r_reg;
        else if (rot_load_skid)
            rot_reg <= skid_reg;
        if (skid_load)
            skid_reg <= r_reg;
    end

    assign rot_valid = rot_valid_reg;
    assign rot       = rot_reg;

endmodule

// ===== rtl/vrm_checker.sv =====
// Port-level checker for the vector-align rotation matrix unit, bound to it.
// Depends on vrm_pkg for the transaction types.
module vrm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              vec_valid,
    input logic              vec_ready,
    input logic              rot_valid,
    input logic              rot_ready,
    input vrm_pkg::vrm_out_t rot
);

    // a stalled result transaction holds
    a_rot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid && !rot_ready |=> rot_valid && $stable(rot))
        else $error("rot transaction dropped or changed while stalled");

    // nothing leaves the unit while in reset
    a_rst_quiet: assert property (@(posedge clk)
        !rst_n |-> !rot_valid)
        else $error("rot_valid high during reset");

    // degenerate results carry the identity
    a_degen_ident: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid && rot.degenerate |->
            rot.r00 == vrm_pkg::OUT_ONE && rot.r11 == vrm_pkg::OUT_ONE &&
            rot.r22 == vrm_pkg::OUT_ONE && rot.r01 == 16'sd0 && rot.r02 == 16'sd0 &&
            rot.r10 == 16'sd0 && rot.r12 == 16'sd0 && rot.r20 == 16'sd0 &&
            rot.r21 == 16'sd0)
        else $error("degenerate result is not the identity");

    // r00, r01, r11, r22 in saturation bounds; r12, r20 lower bound only
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid |->
            $signed(rot.r00) >= -16'sd16384 && $signed(rot.r00) <= 16'sd16384 &&
            $signed(rot.r11) >= -16'sd16384 && $signed(rot.r11) <= 16'sd16384 &&
            $signed(rot.r22) >= -16'sd16384 && $signed(rot.r22) <= 16'sd16384 &&
            $signed(rot.r01) >= -16'sd16384 && $signed(rot.r01) <= 16'sd16384 &&
            $signed(rot.r12) >= -16'sd16384 && $signed(rot.r20) >= -16'sd16384)
        else $error("matrix entry outside Q2.14 range");

endmodule

bind vector_align_rotation_matrix_unit vrm_checker u_vrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .vec_valid (vec_valid),
    .vec_ready (vec_ready),
    .rot_valid (rot_valid),
    .rot_ready (rot_ready),
    .rot       (rot)
);

// ===== bench/vector_align_rotation_matrix_unit_test.sv =====
// Self-checking bench for vector_align_rotation_matrix_unit: random and directed
// vector pairs, valid/ready gaps on both sides, in-order compare. Depends on vrm_pkg.
module vector_align_rotation_matrix_unit_test;
    import vrm_pkg::*;

    localparam int LATENCY = 107;
    localparam int RANDOM_PAIRS = 1430;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint Q30 = 64'sd1 << 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic vec_valid = 1'b0;
    logic vec_ready;
    vrm_in_t vec = '0;
    logic rot_valid;
    logic rot_ready = 1'b0;
    vrm_out_t rot;

    vrm_in_t pending_pairs[$];
    vrm_out_t expected_matrices[$];
    int mismatch_count = 0;
    longint cycle_count = 0;
    bit stimulus_done = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_off = 0;
    bit hold_off_done = 0;

    vector_align_rotation_matrix_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .vec_valid(vec_valid), .vec_ready(vec_ready), .vec(vec),
        .rot_valid(rot_valid), .rot_ready(rot_ready), .rot(rot)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Q1.30 unit vector; returns 0 on zero length
    function automatic bit unit_vector(input longint x, y, z, output longint u[3]);
        longint comp[3];
        longint unsigned n;
        longint s;
        comp = '{x, y, z};
        n = x * x + y * y + z * z;
        if (n == 0)
            return 0;
        s = int_sqrt(n << 30);
        for (int k = 0; k < 3; k++)
        begin
            u[k] = round_div(comp[k] * (64'sd1 << 45), s);
            if (u[k] > Q30) u[k] = Q30;
            if (u[k] < -Q30) u[k] = -Q30;
        end
        return 1;
    endfunction

    function automatic vrm_out_t rotation_between(vrm_in_t p);
        longint a[3], b[3], v[3], m[3][3], r[3][3];
        longint c, d, w, e;
        bit degen;
        vrm_out_t res;
        degen = 0;
        if (!unit_vector(p.from_x, p.from_y, p.from_z, a)) degen = 1;
        if (!unit_vector(p.to_x, p.to_y, p.to_z, b)) degen = 1;
        if (!degen)
        begin
            c = round_div(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], Q30);
            d = Q30 + c;
            if (d <= (64'sd1 << 16)) degen = 1;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r[i][j] = (i == j) ? 16384 : 0;
        if (!degen)
        begin
            v[0] = round_div(a[1] * b[2] - a[2] * b[1], Q30);
            v[1] = round_div(a[2] * b[0] - a[0] * b[2], Q30);
            v[2] = round_div(a[0] * b[1] - a[1] * b[0], Q30);
            m = '{'{0, -v[2], v[1]}, '{v[2], 0, -v[0]}, '{-v[1], v[0], 0}};
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    w = 0;
                    for (int k = 0; k < 3; k++)
                        w += m[i][k] * m[k][j];
                    e = ((i == j) ? Q30 : 0) + m[i][j] + round_div(w, d);
                    e = round_div(e, 64'sd1 << 16);
                    if (e > 16384) e = 16384;
                    if (e < -16384) e = -16384;
                    r[i][j] = e;
                end
        end
        res.r00 = r[0][0]; res.r01 = r[0][1]; res.r02 = r[0][2];
        res.r10 = r[1][0]; res.r11 = r[1][1]; res.r12 = r[1][2];
        res.r20 = r[2][0]; res.r21 = r[2][1]; res.r22 = r[2][2];
        res.degenerate = degen;
        return res;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(9) < 6)
            return 0;
        if ($urandom_range(9) < 8)
            return $urandom_range(3);
        return $urandom_range(40);
    endfunction

    function automatic logic signed [15:0] random_comp(int scale);
        case (scale)
            0: return $urandom;
            1: return $signed(16'($urandom_range(255))) - 16'sd128;
            default: return $signed(16'($urandom_range(7))) - 16'sd4;
        endcase
    endfunction

    function automatic vrm_in_t make_pair(logic signed [15:0] fx, fy, fz, tx, ty, tz);
        vrm_in_t p;
        p.from_x = fx; p.from_y = fy; p.from_z = fz;
        p.to_x = tx; p.to_y = ty; p.to_z = tz;
        return p;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (vec_valid && vec_ready)
            begin
                expected_matrices.push_back(rotation_between(vec));
                void'(pending_pairs.pop_front());
                send_gap = random_gap();
            end
            if ((!vec_valid || vec_ready) && pending_pairs.size() > 0 && send_gap == 0
                && !(vec_valid && vec_ready && pending_pairs.size() == 0))
            begin
                vec_valid <= 1'b1;
                vec <= pending_pairs[0];
            end
            else if (vec_valid && vec_ready)
                vec_valid <= 1'b0;
            if (send_gap > 0 && !(vec_valid && !vec_ready))
                send_gap--;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        vrm_out_t want;
        if (rst_n)
        begin
            if (rot_valid && rot_ready)
            begin
                if (expected_matrices.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected transaction: %p", rot);
                end
                else
                begin
                    want = expected_matrices.pop_front();
                    if (rot !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", want, rot);
                    end
                end
            end
            // one long hold-off once the pipeline is busy
            if (!hold_off_done && expected_matrices.size() > 60)
            begin
                hold_off_done = 1;
                hold_off = 300;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                rot_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rot_ready <= 1'b0;
            end
            else
            begin
                rot_ready <= 1'b1;
                recv_gap = random_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("vector_align_rotation_matrix_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        int scale;
        logic signed [15:0] fx, fy, fz;
        // directed: extremes, zero length, parallel, opposite, near-opposite
        pending_pairs.push_back(make_pair(0, 0, 0, 1, 2, 3));
        pending_pairs.push_back(make_pair(5, -7, 9, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(1, 0, 0, 1, 0, 0));
        pending_pairs.push_back(make_pair(1, 2, 3, 1000, 2000, 3000));
        pending_pairs.push_back(make_pair(1, 0, 0, -1, 0, 0));
        pending_pairs.push_back(make_pair(3, -4, 5, -3, 4, -5));
        pending_pairs.push_back(make_pair(32767, 0, 0, -32768, 1, 0));
        pending_pairs.push_back(make_pair(32767, 0, 0, -32768, 200, 0));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768));
        pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767, -32768, 0));
        pending_pairs.push_back(make_pair(1, 0, 0, 0, 1, 0));
        pending_pairs.push_back(make_pair(0, 1, 0, 0, 0, 1));
        pending_pairs.push_back(make_pair(0, 0, -1, 1, 0, 0));
        pending_pairs.push_back(make_pair(-1, -1, -1, 1, 1, 1));
        pending_pairs.push_back(make_pair(1, 1, 0, -1, 1, 0));
        pending_pairs.push_back(make_pair(-21846, 21845, -1, 1, -1, 0));
        pending_pairs.push_back(make_pair(0, 0, 1, 0, 0, 1));
        pending_pairs.push_back(make_pair(1, 0, 0, 0, 0, -1));
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            scale = $urandom_range(2);
            fx = random_comp(scale); fy = random_comp(scale); fz = random_comp(scale);
            case ($urandom_range(9))
                0: pending_pairs.push_back(make_pair(fx, fy, fz, -fx, -fy, fz ^ 16'sd1));
                1: pending_pairs.push_back(make_pair(fx, fy, fz, fx, fy, fz));
                2: pending_pairs.push_back(make_pair(fx, fy, fz, -fx, -fy, -fz));
                default: pending_pairs.push_back(make_pair(fx, fy, fz,
                    random_comp(scale), random_comp(scale), random_comp(scale)));
            endcase
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_pairs.size() == 0 && !vec_valid);
        wait (expected_matrices.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatch_count == 0 && expected_matrices.size() == 0)
            $display("vector_align_rotation_matrix_unit regression: pass");
        else
            $display("vector_align_rotation_matrix_unit regression: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/vrm_pkg.sv
rtl/vector_align_rotation_matrix_unit.sv
rtl/vrm_checker.sv
bench/vector_align_rotation_matrix_unit_test.sv
